// ===== sv/rsrf_pkg.sv =====
// ----------------------------------------------------------------------------
// rsrf_pkg
// Shared types and constants for the ROM signature revision finder.
// ----------------------------------------------------------------------------
package rsrf_pkg;

  localparam int unsigned KEY_CHARS_DEF = 13;
  localparam int unsigned KEY_MAX       = 16;

  localparam logic [7:0] LETTER_LO = 8'h41;  // 'A'
  localparam logic [7:0] LETTER_HI = 8'h5A;  // 'Z'

  // Signature text, one ASCII code per character; unused tail holds NUL.
  localparam logic [7:0] KEY_TEXT [KEY_MAX] = '{
    8'h56, 8'h65, 8'h72, 8'h73, 8'h69, 8'h6F, 8'h6E, 8'h20,
    8'h48, 8'h50, 8'h34, 8'h38, 8'h2D, 8'h00, 8'h00, 8'h00
  };

  typedef struct packed {
    logic       scan_done;
    logic       matched;
    logic [6:0] revision_letter;
  } result_t;

endpackage

// ===== sv/rsrf_matcher.sv =====
// ----------------------------------------------------------------------------
// rsrf_matcher
// Nibble history window, parallel signature compare and revision latch.
// ----------------------------------------------------------------------------
module rsrf_matcher #(
  parameter int unsigned KEY_CHARS = rsrf_pkg::KEY_CHARS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [3:0]        rom_nibble,
  input  logic              end_of_rom,
  output rsrf_pkg::result_t result
);

  localparam int unsigned SPAN_NIBS = 2 * (KEY_CHARS + 1);
  localparam int unsigned HIST_NIBS = SPAN_NIBS - 1;
  localparam int unsigned FILL_W    = $clog2(HIST_NIBS + 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(HIST_NIBS);

  // nibble i sits at bits [4i +: 4], oldest at i = 0
  logic [HIST_NIBS*4-1:0] window;
  logic [FILL_W-1:0]      fill;
  logic                   found;
  logic [6:0]             revision;

  logic [SPAN_NIBS*4-1:0] span;
  logic                   key_hit;
  logic [7:0]             letter;
  logic                   letter_ok;
  logic                   take;
  logic                   found_next;
  logic [6:0]             revision_next;

  assign span = {rom_nibble, window};

  // each character is a pair of nibbles, low nibble first
  always_comb begin
    key_hit = 1'b1;
    for (int k = 0; k < KEY_CHARS; k++) begin
      if (span[8*k +: 8] != rsrf_pkg::KEY_TEXT[k]) key_hit = 1'b0;
    end
  end

  assign letter        = span[8*KEY_CHARS +: 8];
  assign letter_ok     = (letter >= rsrf_pkg::LETTER_LO) && (letter <= rsrf_pkg::LETTER_HI);
  assign take          = (fill == FILL_FULL) && !found && key_hit && letter_ok;
  assign found_next    = found | take;
  assign revision_next = take ? letter[6:0] : revision;

  assign result.revision_letter = revision_next;
  assign result.matched         = found_next;
  assign result.scan_done       = end_of_rom;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      found    <= 1'b0;
      revision <= rsrf_pkg::LETTER_LO[6:0];
    end else if (accept) begin
      if (end_of_rom) begin
        // start a new scan with the next beat
        fill     <= '0;
        found    <= 1'b0;
        revision <= rsrf_pkg::LETTER_LO[6:0];
      end else begin
        if (fill != FILL_FULL) fill <= fill + FILL_W'(1);
        found    <= found_next;
        revision <= revision_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) window <= span[SPAN_NIBS*4-1:4];
  end

endmodule

// ===== sv/rsrf_out_buf.sv =====
// ----------------------------------------------------------------------------
// rsrf_out_buf
// Output register with a skid stage, so input and output stall separately.
// ----------------------------------------------------------------------------
module rsrf_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rsrf_pkg::result_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rsrf_pkg::result_t out_data
);

  logic              main_valid;
  logic              skid_valid;
  rsrf_pkg::result_t main_data;
  rsrf_pkg::result_t skid_data;
  logic              in_fire;

  assign in_ready  = !skid_valid;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_valid && out_ready) begin
      if (skid_valid) begin
        main_data  <= skid_data;
        skid_valid <= 1'b0;
      end else if (in_fire) begin
        main_data <= in_data;
      end else begin
        main_valid <= 1'b0;
      end
    end else if (!main_valid) begin
      if (in_fire) begin
        main_data  <= in_data;
        main_valid <= 1'b1;
      end
    end else if (in_fire) begin
      // main beat is stalled: park the new one
      skid_data  <= in_data;
      skid_valid <= 1'b1;
    end
  end

endmodule

// ===== sv/rom_signature_revision_finder.sv =====
// ----------------------------------------------------------------------------
// rom_signature_revision_finder
// Finds the revision letter that follows the version signature in a ROM image.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one ROM nibble per beat in address order, s_tlast on the
//   final nibble of the image. Master side gives one result beat per input
//   beat: the revision letter found so far ('A' until a match), the matched
//   flag, and m_tlast on the result of the final nibble.
//   Each result is registered, in the skid stage if the receiver stalls.
//   Throughput is one beat per cycle while s_tready is high; the parallel
//   compare of the whole nibble window against the signature is in that cycle.
//   After the s_tlast beat the scan state clears, so the next beat starts a
//   new image. Reset clears the scan state and empties the output stages.
//   When the receiver stalls, one result waits in the output register and a
//   second in the skid stage; s_tready drops only once both are full.
// ----------------------------------------------------------------------------
module rom_signature_revision_finder #(
  parameter int unsigned KEY_CHARS = rsrf_pkg::KEY_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [3:0] rom_nibble, [7:4] zero
  input  logic       s_tlast,   // end_of_rom
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [6:0] revision_letter, [7] matched
  output logic       m_tlast    // scan_done
);

  logic              accept;
  rsrf_pkg::result_t result;
  rsrf_pkg::result_t out_result;

  assign accept = s_tvalid && s_tready;

  rsrf_matcher #(
    .KEY_CHARS(KEY_CHARS)
  ) u_matcher (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .rom_nibble (s_tdata[3:0]),
    .end_of_rom (s_tlast),
    .result     (result)
  );

  rsrf_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (result),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_result)
  );

  assign m_tdata = {out_result.matched, out_result.revision_letter};
  assign m_tlast = out_result.scan_done;

endmodule
